>>> rtl/core/blyh_pkg.sv
// Shared constants for the Birks light-yield hit accumulator.
`default_nettype none
package blyh_pkg;
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_C1_LIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C1_HEAVY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C2       = 2'd2;

    localparam logic [31:0] C1_LIGHT_RST = 32'd54103273;
    localparam logic [31:0] C1_HEAVY_RST = 32'd30916156;
    localparam logic [31:0] C2_RST       = 32'd38714;

    localparam int unsigned PAD_OUT_W   = 13;
    localparam int unsigned DVD_W       = 56;
    localparam int unsigned DVS_W       = 50;
    localparam int unsigned X_W         = 48;
    localparam int unsigned PROD_W      = 96;
    localparam int unsigned CNT_W       = 6;
    localparam int unsigned DIV_STEPS   = 56;
    localparam int unsigned COEF_STEPS  = 32;
    localparam int unsigned SQ_STEPS    = 48;
    localparam logic [39:0] E_MAX       = 40'hFF_FFFF_FFFF;
    localparam logic [47:0] L_MAX       = 48'hFFFF_FFFF_FFFF;
endpackage
`default_nettype wire

>>> rtl/core/birks_light_yield_hit_accumulator.sv
// Birks-law quenched light computation and per-hit accumulation.
//
// The input channel takes one particle step per transaction and the output
// channel gives one finished hit per transaction; both use valid and stall.
// Configuration writes go through a plain write port; the user must issue
// them only while the block is idle, which the block itself does not enforce.
// A charged step with nonzero length passes through a restoring divider for
// dE/dx, a bit-serial pass for both Birks coefficient products, a bit-serial
// square term, a state for the denominator, a second division for the light,
// a state to update the sums and the idle state to take the next step. When
// the denominator saturates the second division is skipped. A neutral or
// zero-length step goes from idle straight to the sum update. One step is
// in work at a time, so the iterative divider and multiplier set the
// throughput.
// A finished hit waits in the output register; the next step is accepted
// while it waits, and the block holds only when a second hit is ready
// before the first one is taken.
// Reset restores the default coefficients and an empty hit with paddle -1.
`default_nettype none
module birks_light_yield_hit_accumulator #(
    parameter int unsigned PADDLE_BITS = 12
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [blyh_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [31:0]                            i_cfg_data,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic                                   i_step_entering,
    input  wire logic                                   i_step_ending,
    input  wire logic signed [7:0]                      i_particle_charge,
    input  wire logic [31:0]                            i_step_length_um,
    input  wire logic [31:0]                            i_energy_deposit_ev,
    input  wire logic [39:0]                            i_track_time_ps,
    input  wire logic [31:0]                            i_track_length_um,
    input  wire logic [PADDLE_BITS-1:0]                 i_volume_paddle,
    input  wire logic [23:0]                            i_track_number,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic [23:0]                                 o_hit_track,
    output logic signed [blyh_pkg::PAD_OUT_W-1:0]       o_hit_paddle,
    output logic [39:0]                                 o_hit_entry_time_ps,
    output logic [31:0]                                 o_hit_entry_length_um,
    output logic [39:0]                                 o_hit_energy_ev,
    output logic [47:0]                                 o_hit_light_yield
);
    typedef enum logic [2:0] {
        S_IDLE, S_DIVX, S_COEF, S_SQ, S_DEN, S_DIVL, S_FIN
    } t_state;

    t_state                                r_state;
    logic [blyh_pkg::CNT_W-1:0]            r_cnt;
    logic [31:0]                           r_c1l, r_c1h, r_c2;
    logic [39:0]                           r_esum;
    logic [47:0]                           r_lsum;
    logic [39:0]                           r_etime;
    logic [31:0]                           r_elen;
    logic [blyh_pkg::PAD_OUT_W-1:0]        r_epad;
    logic                                  r_ending;
    logic [23:0]                           r_track;
    logic [31:0]                           r_e;
    logic [39:0]                           r_light;
    logic [blyh_pkg::DVD_W-1:0]            r_dvd;
    logic [blyh_pkg::DVS_W-1:0]            r_dvs;
    logic [blyh_pkg::DVS_W-1:0]            r_rem;
    logic [blyh_pkg::X_W-1:0]              r_x;
    logic [blyh_pkg::X_W-1:0]              r_t1;
    logic [blyh_pkg::X_W-1:0]              r_ma;
    logic [31:0]                           r_mb;
    logic [blyh_pkg::PROD_W-1:0]           r_pa, r_pb;

    logic [blyh_pkg::DVS_W:0]              trial, diff;
    logic                                  ge;
    logic [blyh_pkg::DVD_W-1:0]            dvd_next;
    logic [blyh_pkg::DVS_W-1:0]            rem_next;
    logic [blyh_pkg::X_W:0]                sa, sb;
    logic [blyh_pkg::PROD_W-1:0]           pa_next, pb_next;
    logic [blyh_pkg::DVS_W-1:0]            den;
    logic                                  den_sat;
    logic [40:0]                           e_add;
    logic [39:0]                           e_base;
    logic [48:0]                           l_add;
    logic                                  heavy;
    logic                                  no_light;
    logic                                  accept;
    logic                                  out_free;

    always_comb begin
        trial    = {r_rem, r_dvd[blyh_pkg::DVD_W-1]};
        ge       = (trial >= {1'b0, r_dvs});
        diff     = trial - {1'b0, r_dvs};
        rem_next = ge ? diff[blyh_pkg::DVS_W-1:0] : trial[blyh_pkg::DVS_W-1:0];
        dvd_next = {r_dvd[blyh_pkg::DVD_W-2:0], ge};
        sa       = {1'b0, r_pa[95:48]} + (r_ma[0] ? {1'b0, r_x} : 49'd0);
        sb       = {1'b0, r_pb[95:48]} + (r_mb[0] ? {1'b0, r_x} : 49'd0);
        pa_next  = {sa, r_pa[47:1]};
        pb_next  = {sb, r_pb[47:1]};
        den_sat  = |r_pa[95:64];
        den      = 50'h1_0000 + {2'b00, r_t1} + {2'b00, r_pa[63:16]};
        e_base   = i_step_entering ? 40'd0 : r_esum;
        e_add    = {1'b0, e_base} + {9'd0, i_energy_deposit_ev};
        l_add    = {1'b0, r_lsum} + {9'd0, r_light};
        heavy    = (i_particle_charge != 8'sd1) && (i_particle_charge != -8'sd1);
        no_light = (i_particle_charge == 8'sd0) || (i_step_length_um == 32'd0);
        accept   = i_in_valid && !o_in_stall;
        out_free = !o_out_valid || !i_out_stall;
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_c1l       <= blyh_pkg::C1_LIGHT_RST;
            r_c1h       <= blyh_pkg::C1_HEAVY_RST;
            r_c2        <= blyh_pkg::C2_RST;
            r_esum      <= '0;
            r_lsum      <= '0;
            r_etime     <= '0;
            r_elen      <= '0;
            r_epad      <= '1;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    blyh_pkg::REG_C1_LIGHT: r_c1l <= i_cfg_data;
                    blyh_pkg::REG_C1_HEAVY: r_c1h <= i_cfg_data;
                    blyh_pkg::REG_C2:       r_c2  <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_step_entering) begin
                            r_etime <= i_track_time_ps;
                            r_elen  <= i_track_length_um;
                            r_epad  <= blyh_pkg::PAD_OUT_W'(i_volume_paddle);
                        end
                        r_esum   <= e_add[40] ? blyh_pkg::E_MAX : e_add[39:0];
                        r_lsum   <= i_step_entering ? 48'd0 : r_lsum;
                        r_ending <= i_step_ending;
                        r_track  <= i_track_number;
                        r_e      <= i_energy_deposit_ev;
                        r_dvd    <= {8'd0, i_energy_deposit_ev, 16'd0};
                        r_dvs    <= {12'd0, i_step_length_um, 6'd0}
                                  + {13'd0, i_step_length_um, 5'd0}
                                  + {16'd0, i_step_length_um, 2'd0};
                        r_rem    <= '0;
                        r_ma     <= {16'd0, (heavy ? r_c1h : r_c1l)};
                        r_mb     <= r_c2;
                        r_cnt    <= blyh_pkg::CNT_W'(blyh_pkg::DIV_STEPS - 1);
                        if (no_light) begin
                            r_light <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_DIVX;
                        end
                    end
                end
                S_DIVX: begin
                    r_dvd <= dvd_next;
                    r_rem <= rem_next;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_x     <= dvd_next[blyh_pkg::X_W-1:0];
                        r_pa    <= '0;
                        r_pb    <= '0;
                        r_cnt   <= blyh_pkg::CNT_W'(blyh_pkg::COEF_STEPS - 1);
                        r_state <= S_COEF;
                    end
                end
                S_COEF: begin
                    r_pa  <= pa_next;
                    r_pb  <= pb_next;
                    r_ma  <= r_ma >> 1;
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_t1    <= sa[48:1];
                        r_ma    <= sb[48:1];
                        r_pa    <= '0;
                        r_cnt   <= blyh_pkg::CNT_W'(blyh_pkg::SQ_STEPS - 1);
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_pa  <= pa_next;
                    r_ma  <= r_ma >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    r_dvs <= den;
                    r_dvd <= {r_e, 24'd0};
                    r_rem <= '0;
                    r_cnt <= blyh_pkg::CNT_W'(blyh_pkg::DIV_STEPS - 1);
                    if (den_sat) begin
                        r_light <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_DIVL;
                    end
                end
                S_DIVL: begin
                    r_dvd <= dvd_next;
                    r_rem <= rem_next;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_light <= dvd_next[39:0];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_ending) begin
                        r_lsum  <= l_add[48] ? blyh_pkg::L_MAX : l_add[47:0];
                        r_state <= S_IDLE;
                    end else if (r_esum == '0 || out_free) begin
                        if (r_esum != '0) begin
                            o_out_valid           <= 1'b1;
                            o_hit_track           <= r_track;
                            o_hit_paddle          <= r_epad;
                            o_hit_entry_time_ps   <= r_etime;
                            o_hit_entry_length_um <= r_elen;
                            o_hit_energy_ev       <= r_esum;
                            o_hit_light_yield     <= l_add[48] ? blyh_pkg::L_MAX
                                                               : l_add[47:0];
                        end
                        r_esum  <= '0;
                        r_lsum  <= '0;
                        r_etime <= '0;
                        r_elen  <= '0;
                        r_epad  <= '1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> tb/sv/tb_birks_light_yield_hit_accumulator.sv
// Self-checking testbench for the Birks light-yield hit accumulator.
`default_nettype none
module tb_birks_light_yield_hit_accumulator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PADDLE_BITS = 12;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [23:0] track;
        logic [12:0] paddle;
        logic [39:0] entry_time;
        logic [31:0] entry_length;
        logic [39:0] energy;
        logic [47:0] light;
    } t_hit;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [blyh_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_step_entering = 1'b0;
    logic i_step_ending = 1'b0;
    logic signed [7:0] i_particle_charge = '0;
    logic [31:0] i_step_length_um = '0;
    logic [31:0] i_energy_deposit_ev = '0;
    logic [39:0] i_track_time_ps = '0;
    logic [31:0] i_track_length_um = '0;
    logic [PADDLE_BITS-1:0] i_volume_paddle = '0;
    logic [23:0] i_track_number = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [23:0] o_hit_track;
    logic signed [blyh_pkg::PAD_OUT_W-1:0] o_hit_paddle;
    logic [39:0] o_hit_entry_time_ps;
    logic [31:0] o_hit_entry_length_um;
    logic [39:0] o_hit_energy_ev;
    logic [47:0] o_hit_light_yield;

    birks_light_yield_hit_accumulator #(.PADDLE_BITS(PADDLE_BITS)) u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [31:0] c1_light, c1_heavy, c2_coef;
    logic [39:0] energy_acc;
    logic [47:0] light_acc;
    logic [39:0] latched_time;
    logic [31:0] latched_length;
    logic [12:0] latched_paddle;
    t_hit pending_hits[$];
    int errors = 0;
    int steps_sent = 0;
    int hits_seen = 0;
    int idle_cycles = 0;
    int stall_mode = 0;

    function automatic logic [63:0] quenched_light(logic signed [7:0] q, logic [31:0] len,
                                                   logic [31:0] e);
        logic [127:0] x, c1, t1, y, p, t2, d;
        if (q == 0 || len == 0) return 64'd0;
        c1 = {96'd0, ((q >= 2 || q <= -2) ? c1_heavy : c1_light)};
        x = ({96'd0, e} << 16) / (128'd100 * {96'd0, len});
        t1 = (c1 * x) >> 32;
        y = ({96'd0, c2_coef} * x) >> 32;
        p = y * x;
        if (p > 128'hFFFF_FFFF_FFFF_FFFF) begin
            d = 128'hFFFF_FFFF_FFFF_FFFF;
        end else begin
            t2 = p >> 16;
            d = 128'd65536 + t1 + t2;
            if (d > 128'hFFFF_FFFF_FFFF_FFFF) d = 128'hFFFF_FFFF_FFFF_FFFF;
        end
        return 64'((({96'd0, e}) << 24) / d);
    endfunction

    task automatic clear_hit_state();
        energy_acc = '0;
        light_acc = '0;
        latched_time = '0;
        latched_length = '0;
        latched_paddle = 13'h1FFF;
    endtask

    task automatic predict_step(logic ent, logic ends, logic signed [7:0] q,
                                logic [31:0] len, logic [31:0] e, logic [39:0] tm,
                                logic [31:0] tl, logic [PADDLE_BITS-1:0] pad,
                                logic [23:0] trk);
        logic [48:0] esum;
        logic [64:0] lsum;
        t_hit h;
        if (ent) begin
            clear_hit_state();
            latched_time = tm;
            latched_length = tl;
            latched_paddle = 13'(pad);
        end
        esum = {9'd0, energy_acc} + {17'd0, e};
        energy_acc = (esum > 49'(blyh_pkg::E_MAX)) ? blyh_pkg::E_MAX : esum[39:0];
        lsum = {17'd0, light_acc} + {1'b0, quenched_light(q, len, e)};
        light_acc = (lsum > 65'(blyh_pkg::L_MAX)) ? blyh_pkg::L_MAX : lsum[47:0];
        if (ends) begin
            if (energy_acc != 0) begin
                h.track = trk;
                h.paddle = latched_paddle;
                h.entry_time = latched_time;
                h.entry_length = latched_length;
                h.energy = energy_acc;
                h.light = light_acc;
                pending_hits.push_back(h);
            end
            clear_hit_state();
        end
    endtask

    task automatic write_coef(logic [blyh_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == blyh_pkg::REG_C1_LIGHT) c1_light = val;
        else if (idx == blyh_pkg::REG_C1_HEAVY) c1_heavy = val;
        else if (idx == blyh_pkg::REG_C2) c2_coef = val;
    endtask

    task automatic wait_idle();
        while (pending_hits.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Drives one step; called just after a falling edge, returns at a falling edge.
    task automatic send_step(logic ent, logic ends, logic signed [7:0] q,
                             logic [31:0] len, logic [31:0] e, logic [39:0] tm,
                             logic [31:0] tl, logic [PADDLE_BITS-1:0] pad,
                             logic [23:0] trk);
        i_in_valid <= 1'b1;
        i_step_entering <= ent;
        i_step_ending <= ends;
        i_particle_charge <= q;
        i_step_length_um <= len;
        i_energy_deposit_ev <= e;
        i_track_time_ps <= tm;
        i_track_length_um <= tl;
        i_volume_paddle <= pad;
        i_track_number <= trk;
        do @(posedge i_clk); while (o_in_stall);
        predict_step(ent, ends, q, len, e, tm, tl, pad, trk);
        steps_sent++;
        @(negedge i_clk);
    endtask

    task automatic pause_sender();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 300)) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_random_step(logic ent, logic ends);
        logic [31:0] len, e;
        logic signed [7:0] q;
        case ($urandom_range(0, 5))
            0: e = $urandom;
            1: e = 32'hFFFF_FFFF;
            2: e = 32'd0;
            default: e = $urandom_range(1, 5000000);
        endcase
        case ($urandom_range(0, 5))
            0: len = $urandom;
            1: len = 32'd0;
            2: len = $urandom_range(1, 3);
            default: len = $urandom_range(1, 100000);
        endcase
        case ($urandom_range(0, 3))
            0: q = 8'($urandom);
            1: q = 8'sd0;
            default: q = $urandom_range(0, 1) ? 8'sd1 : -8'sd1;
        endcase
        send_step(ent, ends, q, len, e, 40'({$urandom, $urandom}),
                  $urandom, PADDLE_BITS'($urandom), 24'($urandom));
    endtask

    task automatic test_directed();
        send_step(1'b1, 1'b0, 8'sd1, 32'd5000, 32'd1000000, 40'hFF_FFFF_FFFF,
                  32'hFFFF_FFFF, '1, 24'hFFFFFF);
        send_step(1'b0, 1'b0, 8'sd127, 32'd1, 32'hFFFF_FFFF, 40'd5, 32'd7, '0, 24'd0);
        send_step(1'b0, 1'b0, -8'sd128, 32'hFFFF_FFFF, 32'd1, 40'd5, 32'd7, '0, 24'd0);
        send_step(1'b0, 1'b0, 8'sd0, 32'd10, 32'd500, '0, '0, '0, '0);
        send_step(1'b0, 1'b1, -8'sd2, 32'd0, 32'd700, '0, '0, '0, 24'd1234);
        send_step(1'b0, 1'b1, 8'sd1, 32'd100, 32'd50000, '0, '0, '0, 24'd7);
        send_step(1'b1, 1'b1, 8'sd2, 32'd100, 32'd0, 40'd1, 32'd2, 12'd3, 24'd8);
        send_step(1'b1, 1'b1, 8'sd1, 32'd300, 32'd9000, 40'd11, 32'd22, 12'd33, 24'd44);
        send_step(1'b1, 1'b0, 8'sd1, 32'd300, 32'd9000, 40'd11, 32'd22, 12'd34, 24'd44);
        send_step(1'b1, 1'b0, -8'sd1, 32'd300, 32'd900, 40'd12, 32'd23, 12'd35, 24'd45);
        send_step(1'b0, 1'b1, -8'sd1, 32'd300, 32'd900, 40'd13, 32'd24, 12'd36, 24'd46);
        send_step(1'b1, 1'b0, 8'sd3, 32'd1, 32'hFFFF_FFFF, '0, '0, 12'd1, 24'd1);
        repeat (300) send_step(1'b0, 1'b0, 8'sd0, 32'd1, 32'hFFFF_FFFF, '0, '0, '0, '0);
        send_step(1'b0, 1'b1, 8'sd0, 32'd1, 32'hFFFF_FFFF, '0, '0, '0, 24'd2);
        i_in_valid <= 1'b0;
        wait_idle();
    endtask

    task automatic test_config_extremes();
        write_coef(blyh_pkg::REG_C1_LIGHT, 32'hFFFF_FFFF);
        write_coef(blyh_pkg::REG_C1_HEAVY, 32'hFFFF_FFFF);
        write_coef(blyh_pkg::REG_C2, 32'hFFFF_FFFF);
        write_coef(2'd3, 32'h1234_5678);
        send_step(1'b1, 1'b0, 8'sd1, 32'd1, 32'hFFFF_FFFF, 40'd9, 32'd9, 12'd9, 24'd9);
        send_step(1'b0, 1'b1, 8'sd2, 32'd1000, 32'd1000, '0, '0, '0, 24'd10);
        i_in_valid <= 1'b0;
        wait_idle();
        write_coef(blyh_pkg::REG_C1_LIGHT, 32'd0);
        write_coef(blyh_pkg::REG_C1_HEAVY, 32'd0);
        write_coef(blyh_pkg::REG_C2, 32'd0);
        send_step(1'b1, 1'b1, 8'sd1, 32'd10, 32'd123456, 40'd1, 32'd1, 12'd1, 24'd11);
        send_step(1'b1, 1'b1, -8'sd5, 32'd10, 32'd123456, 40'd1, 32'd1, 12'd1, 24'd12);
        i_in_valid <= 1'b0;
        wait_idle();
    endtask

    task automatic test_random_hits(int n_items);
        int sent;
        int seg;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_random_step(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                seg = $urandom_range(0, 6);
                send_random_step(1'b1, seg == 0);
                sent++;
                for (int k = 0; k < seg; k++) begin
                    send_random_step(1'b0, k == seg - 1);
                    sent++;
                end
            end
            if ($urandom_range(0, 2) == 0) pause_sender();
        end
        i_in_valid <= 1'b0;
        wait_idle();
    endtask

    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_hit h;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            hits_seen++;
            if (pending_hits.size() == 0) begin
                $display("%0t: unexpected hit, actual track %h energy %h", $time,
                         o_hit_track, o_hit_energy_ev);
                errors++;
            end else begin
                h = pending_hits.pop_front();
                if ({o_hit_track, o_hit_paddle, o_hit_entry_time_ps, o_hit_entry_length_um,
                     o_hit_energy_ev, o_hit_light_yield} !== h) begin
                    $display("%0t: hit mismatch, expected %h %h %h %h %h %h", $time,
                             h.track, h.paddle, h.entry_time, h.entry_length, h.energy,
                             h.light);
                    $display("%0t:               actual %h %h %h %h %h %h", $time,
                             o_hit_track, o_hit_paddle, o_hit_entry_time_ps,
                             o_hit_entry_length_um, o_hit_energy_ev, o_hit_light_yield);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        c1_light = blyh_pkg::C1_LIGHT_RST;
        c1_heavy = blyh_pkg::C1_HEAVY_RST;
        c2_coef = blyh_pkg::C2_RST;
        clear_hit_state();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_hits(260);
        test_config_extremes();
        write_coef(blyh_pkg::REG_C1_LIGHT, $urandom);
        write_coef(blyh_pkg::REG_C1_HEAVY, $urandom_range(0, 100000000));
        write_coef(blyh_pkg::REG_C2, $urandom_range(0, 1000000));
        test_random_hits(260);
        write_coef(blyh_pkg::REG_C1_LIGHT, blyh_pkg::C1_LIGHT_RST);
        write_coef(blyh_pkg::REG_C1_HEAVY, blyh_pkg::C1_HEAVY_RST);
        write_coef(blyh_pkg::REG_C2, blyh_pkg::C2_RST);
        test_random_hits(260);
        wait_idle();
        if (pending_hits.size() != 0) errors++;
        $display("Sent %0d steps over several coefficient settings; checked %0d hits.",
                 steps_sent, hits_seen);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
